>>> rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types for the streaming Base64 decoder
// Word formats on both channels, the character classes and the queue entry
// that passes from the classifier to the bit packer.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned SextWidth  = 6;
    localparam int unsigned HeldWidth  = 3;
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

    localparam logic [CharWidth-1:0] CharNul   = 8'h00;
    localparam logic [CharWidth-1:0] CharLf    = 8'h0a;
    localparam logic [CharWidth-1:0] CharCr    = 8'h0d;
    localparam logic [CharWidth-1:0] CharPlus  = 8'h2b;
    localparam logic [CharWidth-1:0] CharSlash = 8'h2f;
    localparam logic [CharWidth-1:0] CharPad   = 8'h3d;
    localparam logic [CharWidth-1:0] CharZero  = 8'h30;
    localparam logic [CharWidth-1:0] CharNine  = 8'h39;
    localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
    localparam logic [CharWidth-1:0] CharUpZ   = 8'h5a;
    localparam logic [CharWidth-1:0] CharLoA   = 8'h61;
    localparam logic [CharWidth-1:0] CharLoZ   = 8'h7a;

    localparam logic [SextWidth-1:0] SextLowerBase = 6'd26;
    localparam logic [SextWidth-1:0] SextDigitBase = 6'd52;
    localparam logic [SextWidth-1:0] SextPlus      = 6'd62;
    localparam logic [SextWidth-1:0] SextSlash     = 6'd63;

    localparam logic [HeldWidth-1:0] Held0 = 3'd0;
    localparam logic [HeldWidth-1:0] Held2 = 3'd2;
    localparam logic [HeldWidth-1:0] Held4 = 3'd4;
    localparam logic [HeldWidth-1:0] Held6 = 3'd6;

    typedef enum logic [1:0] {
        CLS_SKIP = 2'd0,
        CLS_PAD  = 2'd1,
        CLS_BAD  = 2'd2,
        CLS_DATA = 2'd3
    } b64d_cls_t;

    typedef struct packed {
        logic [CharWidth-1:0] in_char;
        logic                 end_of_text;
    } b64d_in_word_t;

    typedef struct packed {
        logic [CharWidth-1:0] out_byte;
        logic                 byte_valid;
        logic                 bad_char;
        logic                 last_out;
    } b64d_out_word_t;

    typedef struct packed {
        b64d_cls_t            cls;
        logic [SextWidth-1:0] sextet;
        logic                 last;
    } b64d_entry_t;

    typedef struct packed {
        logic                 not_empty;
        logic                 full;
        logic [QueueCntW-1:0] count;
    } b64d_qstat_t;

    typedef struct packed {
        logic [HeldWidth-1:0] held;
        logic                 pad;
    } b64d_bstat_t;

endpackage

>>> rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: input side of the decoder
// Takes one character word per cycle while not stalled, sorts it into skip,
// padding, bad or data, maps data characters to their 6-bit value and pushes the result.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   src_valid,
    output logic                   src_stall,
    input  b64d_pkg::b64d_in_word_t src_data,
    input  logic                   q_full,
    output logic                   q_push,
    output b64d_pkg::b64d_entry_t  q_entry
);
    import b64d_pkg::*;

    logic [CharWidth-1:0] ch;
    logic                 is_upper;
    logic                 is_lower;
    logic                 is_digit;
    logic [CharWidth-1:0] off_upper;
    logic [CharWidth-1:0] off_lower;
    logic [CharWidth-1:0] off_digit;

    assign ch        = src_data.in_char;
    assign is_upper  = (ch >= CharUpA) && (ch <= CharUpZ);
    assign is_lower  = (ch >= CharLoA) && (ch <= CharLoZ);
    assign is_digit  = (ch >= CharZero) && (ch <= CharNine);
    assign off_upper = ch - CharUpA;
    assign off_lower = ch - CharLoA;
    assign off_digit = ch - CharZero;

    always_comb
    begin
        q_entry.last   = src_data.end_of_text;
        q_entry.sextet = '0;
        q_entry.cls    = CLS_BAD;
        if ((ch == CharCr) || (ch == CharLf) || (ch == CharNul))
        begin
            q_entry.cls = CLS_SKIP;
        end
        else if (ch == CharPad)
        begin
            q_entry.cls = CLS_PAD;
        end
        else if (is_upper)
        begin
            q_entry.cls    = CLS_DATA;
            q_entry.sextet = off_upper[SextWidth-1:0];
        end
        else if (is_lower)
        begin
            q_entry.cls    = CLS_DATA;
            q_entry.sextet = off_lower[SextWidth-1:0] + SextLowerBase;
        end
        else if (is_digit)
        begin
            q_entry.cls    = CLS_DATA;
            q_entry.sextet = off_digit[SextWidth-1:0] + SextDigitBase;
        end
        else if (ch == CharPlus)
        begin
            q_entry.cls    = CLS_DATA;
            q_entry.sextet = SextPlus;
        end
        else if (ch == CharSlash)
        begin
            q_entry.cls    = CLS_DATA;
            q_entry.sextet = SextSlash;
        end
    end

    // Reset holds the input stalled so that no word is taken before the
    // queue pointers are clean.
    logic run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= 1'b1;
        end
    end

    assign src_stall = q_full || !run_reg;
    assign q_push    = src_valid && !src_stall;

endmodule

>>> rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue: short queue between classifier and bit packer
// Two entries deep, so both sides can stall on their own while a word
// still moves every cycle.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64d_pkg::b64d_entry_t push_entry,
    input  logic                  pop,
    output b64d_pkg::b64d_entry_t head,
    output b64d_pkg::b64d_qstat_t status
);
    import b64d_pkg::*;

    b64d_entry_t          slot_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_next;
    logic [QueueCntW-1:0] count_reg;
    logic [QueueCntW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + QueueCntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QueueCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head             = slot_reg[rd_ptr_reg];
    assign status.count     = count_reg;
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == QueueCntW'(QueueDepth));

endmodule

>>> rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: bit packer and result register
// Pops classified words, shifts sextets into the pending bits, emits a byte
// once eight bits are held and keeps the result until it is taken.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_not_empty,
    input  b64d_pkg::b64d_entry_t    q_head,
    output logic                     q_pop,
    output logic                     dst_valid,
    input  logic                     dst_stall,
    output b64d_pkg::b64d_out_word_t dst_data,
    output b64d_pkg::b64d_bstat_t    status
);
    import b64d_pkg::*;

    // Only the low held_reg bits of acc_reg are pending; the rest stay zero.
    logic [SextWidth-1:0] acc_reg;
    logic [SextWidth-1:0] acc_next;
    logic [HeldWidth-1:0] held_reg;
    logic [HeldWidth-1:0] held_next;
    logic                 pad_reg;
    logic                 pad_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    b64d_out_word_t       out_word_reg;
    b64d_out_word_t       result;
    logic                 take;

    assign take  = !out_valid_reg || !dst_stall;
    assign q_pop = q_not_empty && take;

    always_comb
    begin
        acc_next          = acc_reg;
        held_next         = held_reg;
        pad_next          = pad_reg;
        result.out_byte   = '0;
        result.byte_valid = 1'b0;
        result.bad_char   = 1'b0;
        result.last_out   = q_head.last;
        case (q_head.cls)
            CLS_PAD:
            begin
                pad_next = 1'b1;
            end
            CLS_BAD:
            begin
                result.bad_char = 1'b1;
            end
            CLS_DATA:
            begin
                if (!pad_reg)
                begin
                    unique case (held_reg)
                        Held0:
                        begin
                            acc_next  = q_head.sextet;
                            held_next = Held6;
                        end
                        Held2:
                        begin
                            result.out_byte   = {acc_reg[1:0], q_head.sextet};
                            result.byte_valid = 1'b1;
                            acc_next          = '0;
                            held_next         = Held0;
                        end
                        Held4:
                        begin
                            result.out_byte   = {acc_reg[3:0], q_head.sextet[5:2]};
                            result.byte_valid = 1'b1;
                            acc_next          = {4'b0, q_head.sextet[1:0]};
                            held_next         = Held2;
                        end
                        Held6:
                        begin
                            result.out_byte   = {acc_reg[5:0], q_head.sextet[5:4]};
                            result.byte_valid = 1'b1;
                            acc_next          = {2'b0, q_head.sextet[3:0]};
                            held_next         = Held4;
                        end
                        default:
                        begin
                            acc_next  = '0;
                            held_next = Held0;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        // The end marker drops leftover bits and clears padding.
        if (q_head.last)
        begin
            acc_next  = '0;
            held_next = Held0;
            pad_next  = 1'b0;
        end
    end

    assign out_valid_next = q_pop ? 1'b1 : (out_valid_reg && dst_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            held_reg      <= Held0;
            pad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                acc_reg  <= acc_next;
                held_reg <= held_next;
                pad_reg  <= pad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_word_reg <= result;
        end
    end

    assign dst_valid   = out_valid_reg;
    assign dst_data    = out_word_reg;
    assign status.held = held_reg;
    assign status.pad  = pad_reg;

endmodule

>>> rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming Base64 decoder
// Path: an accepted word is written into the queue, then popped into the result register.
// Throughput: one character word per cycle; the two-entry queue between the
// classifier and the bit packer plus the result register absorb stalls.
// Reset: asynchronous, active low; clears pending bits, padding state and the
// queue, and holds the input stalled until the run register is set after release.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     src_valid,
    output logic                     src_stall,
    input  b64d_pkg::b64d_in_word_t  src_data,
    output logic                     dst_valid,
    input  logic                     dst_stall,
    output b64d_pkg::b64d_out_word_t dst_data
);
    import b64d_pkg::*;

    logic        q_push;
    logic        q_pop;
    b64d_entry_t q_entry;
    b64d_entry_t q_head;
    b64d_qstat_t q_status;
    b64d_bstat_t b_status;

    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .q_full    (q_status.full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_status.not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .dst_data    (dst_data),
        .status      (b_status)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QueueCntW'(QueueDepth))
        else $error("queue holds more words than it has entries");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.not_empty)
        else $error("word popped from an empty queue");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.last) |=> (b_status.held == Held0 && !b_status.pad))
        else $error("decoder state not cleared after the end marker");

    a_held_even: assert property (@(posedge clk) disable iff (!rst_n)
        !b_status.held[0])
        else $error("odd number of pending bits");
`endif

endmodule
